FILE: sv/epmm_pkg.sv
`default_nettype none
package epmm_pkg;

	// Widest coordinate that the shared helpers handle.
	localparam int COORD_MAX = 16;

	// Fixed widths of the result fields.
	localparam int SHIFT_W  = 13;
	localparam int SPREAD_W = 29;
	localparam int AREA_W   = 20;

	// Request type codes on the input channel; the fourth code is unused.
	localparam logic [1:0] REQ_REF   = 2'd0;
	localparam logic [1:0] REQ_TRACK = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// Result kind codes.
	localparam logic RES_REF   = 1'b0;
	localparam logic RES_TRACK = 1'b1;

	// Operation handed from the front end to the back end.
	typedef enum logic [1:0] {
		OP_REF,
		OP_TRACK,
		OP_CLEAR
	} op_t;

	typedef logic [COORD_MAX-1:0] coord_t;

	// x,y pairs of the left, top, right and bottom extreme points.
	typedef coord_t [7:0] ext_t;

	// Queue status seen by the front end, the back end and the top level.
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	// Merges one point into a set of extremes; fresh means the set is empty.
	function automatic ext_t merge_pt(ext_t e, logic fresh, coord_t x, coord_t y);
		ext_t r;
		r = e;
		if (fresh) begin
			for (int i = 0; i < 4; i++) begin
				r[2*i]   = x;
				r[2*i+1] = y;
			end
		end else begin
			if (x < e[0] || (x == e[0] && y < e[1])) begin
				r[0] = x;
				r[1] = y;
			end
			if (y < e[3] || (y == e[3] && x > e[2])) begin
				r[2] = x;
				r[3] = y;
			end
			if (x > e[4] || (x == e[4] && y > e[5])) begin
				r[4] = x;
				r[5] = y;
			end
			if (y > e[7] || (y == e[7] && x < e[6])) begin
				r[6] = x;
				r[7] = y;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: sv/epmm_front.sv
`default_nettype none
module epmm_front #(
	parameter int CW = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            req_type,
	input  wire logic [CW-1:0]         pos_x,
	input  wire logic [CW-1:0]         pos_y,
	input  wire logic                  frame_end,
	input  wire epmm_pkg::q_status_t   q_status,
	output logic                       push,
	output epmm_pkg::op_t              push_op,
	output logic [7:0][CW-1:0]         push_ext
);

	logic [7:0][CW-1:0] fe_q;
	logic               has_q;
	logic               accept;
	logic               is_pt;
	epmm_pkg::ext_t     fe_wide;
	epmm_pkg::ext_t     merged_wide;
	logic [7:0][CW-1:0] merged;

	// The front end takes an item whenever the queue has room.
	assign in_ready = !q_status.full;

	// Merge the incoming point into the extremes of the frame in progress.
	always_comb begin
		accept = in_valid && in_ready;
		is_pt  = (req_type == epmm_pkg::REQ_REF) || (req_type == epmm_pkg::REQ_TRACK);
		for (int i = 0; i < 8; i++) begin
			fe_wide[i] = epmm_pkg::coord_t'(fe_q[i]);
		end
		merged_wide = epmm_pkg::merge_pt(fe_wide, !has_q,
			epmm_pkg::coord_t'(pos_x), epmm_pkg::coord_t'(pos_y));
		for (int i = 0; i < 8; i++) begin
			merged[i] = merged_wide[i][CW-1:0];
		end
	end

	// A frame end or a clear request becomes one queue entry.
	always_comb begin
		push     = accept && ((is_pt && frame_end) || (req_type == epmm_pkg::REQ_CLEAR));
		push_ext = merged;
		if (req_type == epmm_pkg::REQ_CLEAR) begin
			push_op = epmm_pkg::OP_CLEAR;
		end else if (req_type == epmm_pkg::REQ_REF) begin
			push_op = epmm_pkg::OP_REF;
		end else begin
			push_op = epmm_pkg::OP_TRACK;
		end
	end

	// Frame extremes; the frame closes on its last point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_q <= 1'b0;
			fe_q  <= '0;
		end else if (accept && is_pt) begin
			fe_q  <= merged;
			has_q <= !frame_end;
		end
	end

endmodule
`default_nettype wire

FILE: sv/epmm_queue.sv
`default_nettype none
module epmm_queue #(
	parameter int W     = 82,
	parameter int DEPTH = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire logic [W-1:0]         push_data,
	input  wire logic                 pop,
	output logic [W-1:0]              pop_data,
	output epmm_pkg::q_status_t       status
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign pop_data     = mem_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CNTW'(DEPTH));

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == AW'(DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (pop) begin
				if (rd_ptr_q == AW'(DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/epmm_back.sv
`default_nettype none
module epmm_back #(
	parameter int CW = 10
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire epmm_pkg::q_status_t               q_status,
	input  wire epmm_pkg::op_t                     head_op,
	input  wire logic [7:0][CW-1:0]                head_ext,
	output logic                                   pop,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   result_kind,
	output logic                                   matched,
	output logic signed [epmm_pkg::SHIFT_W-1:0]    shift_x_quarters,
	output logic signed [epmm_pkg::SHIFT_W-1:0]    shift_y_quarters,
	output logic [epmm_pkg::SPREAD_W-1:0]          spread_x,
	output logic [epmm_pkg::SPREAD_W-1:0]          spread_y,
	output logic [epmm_pkg::AREA_W-1:0]            area
);

	localparam int DW   = CW + 1;
	localparam int SW   = CW + 3;
	localparam int VW   = CW + 4;
	localparam int QW   = 2 * VW;
	localparam int SPW  = QW + 2;
	localparam int LW   = epmm_pkg::AREA_W + 2;
	localparam int CMPW = (SPW > LW) ? SPW : LW;

	// Accumulated reference.
	logic [7:0][CW-1:0]            ref_ext_q;
	logic                          ref_valid_q;
	logic [epmm_pkg::AREA_W-1:0]   ref_area_q;

	// Head-of-queue evaluation.
	epmm_pkg::ext_t                ref_wide;
	epmm_pkg::ext_t                head_wide;
	epmm_pkg::ext_t                m0, m1, m2, m3;
	logic [CW-1:0]                 base;
	logic [CW-1:0]                 height;
	logic [2*CW-1:0]               area_prod;
	logic [epmm_pkg::AREA_W-1:0]   area_new;
	logic signed [DW-1:0]          dx [4];
	logic signed [DW-1:0]          dy [4];
	logic signed [SW-1:0]          sx;
	logic signed [SW-1:0]          sy;
	logic                          ready1, ready2, ready3;

	// Stage 1: displacements.
	logic                          v_s1;
	logic                          kind_s1;
	logic                          elig_s1;
	logic [epmm_pkg::AREA_W-1:0]   area_s1;
	logic signed [DW-1:0]          dx_s1 [4];
	logic signed [DW-1:0]          dy_s1 [4];
	logic signed [SW-1:0]          sx_s1;
	logic signed [SW-1:0]          sy_s1;

	// Stage 2: squared deviations.
	logic signed [VW-1:0]          vx [4];
	logic signed [VW-1:0]          vy [4];
	logic signed [QW-1:0]          px [4];
	logic signed [QW-1:0]          py [4];
	logic                          v_s2;
	logic                          kind_s2;
	logic                          elig_s2;
	logic [epmm_pkg::AREA_W-1:0]   area_s2;
	logic [QW-1:0]                 sqx_s2 [4];
	logic [QW-1:0]                 sqy_s2 [4];
	logic signed [SW-1:0]          sx_s2;
	logic signed [SW-1:0]          sy_s2;

	// Stage 3: result register.
	logic [SPW-1:0]                spx;
	logic [SPW-1:0]                spy;
	logic [LW-1:0]                 lim;
	logic                          v_s3;
	logic                          kind_s3;
	logic                          matched_s3;
	logic signed [epmm_pkg::SHIFT_W-1:0] shx_s3;
	logic signed [epmm_pkg::SHIFT_W-1:0] shy_s3;
	logic [epmm_pkg::SPREAD_W-1:0] spx_s3;
	logic [epmm_pkg::SPREAD_W-1:0] spy_s3;
	logic [epmm_pkg::AREA_W-1:0]   area_s3;

	// Stall chain: a stage moves when the one after it is free or draining.
	assign ready3 = !v_s3 || out_ready;
	assign ready2 = !v_s2 || ready3;
	assign ready1 = !v_s1 || ready2;
	assign pop    = !q_status.empty && ready1;

	// Reference merge, area and displacements of the queue head.
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			ref_wide[i]  = epmm_pkg::coord_t'(ref_ext_q[i]);
			head_wide[i] = epmm_pkg::coord_t'(head_ext[i]);
		end
		m0 = epmm_pkg::merge_pt(ref_wide, !ref_valid_q, head_wide[0], head_wide[1]);
		m1 = epmm_pkg::merge_pt(m0, 1'b0, head_wide[2], head_wide[3]);
		m2 = epmm_pkg::merge_pt(m1, 1'b0, head_wide[4], head_wide[5]);
		m3 = epmm_pkg::merge_pt(m2, 1'b0, head_wide[6], head_wide[7]);
		base      = head_ext[2] - head_ext[0];
		height    = head_ext[7] - head_ext[3];
		area_prod = base * height;
		area_new  = epmm_pkg::AREA_W'(area_prod);
		for (int i = 0; i < 4; i++) begin
			dx[i] = $signed({1'b0, head_ext[2*i]}) - $signed({1'b0, ref_ext_q[2*i]});
			dy[i] = $signed({1'b0, head_ext[2*i+1]}) - $signed({1'b0, ref_ext_q[2*i+1]});
		end
		sx = SW'(dx[0]) + SW'(dx[1]) + SW'(dx[2]) + SW'(dx[3]);
		sy = SW'(dy[0]) + SW'(dy[1]) + SW'(dy[2]) + SW'(dy[3]);
	end

	// Reference state updates in queue order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_ext_q   <= '0;
			ref_valid_q <= 1'b0;
			ref_area_q  <= '0;
		end else if (pop) begin
			unique case (head_op)
				epmm_pkg::OP_CLEAR: begin
					ref_ext_q   <= '0;
					ref_valid_q <= 1'b0;
					ref_area_q  <= '0;
				end
				epmm_pkg::OP_REF: begin
					for (int i = 0; i < 8; i++) begin
						ref_ext_q[i] <= m3[i][CW-1:0];
					end
					ref_valid_q <= 1'b1;
					ref_area_q  <= area_new;
				end
				default: begin
					ref_valid_q <= ref_valid_q;
				end
			endcase
		end
	end

	// Stage 1 register; a clear request leaves no result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready1) begin
			v_s1 <= pop && (head_op != epmm_pkg::OP_CLEAR);
		end
	end

	always_ff @(posedge clk) begin
		if (ready1) begin
			kind_s1 <= (head_op == epmm_pkg::OP_TRACK) ? epmm_pkg::RES_TRACK
			                                           : epmm_pkg::RES_REF;
			elig_s1 <= ref_valid_q;
			area_s1 <= (head_op == epmm_pkg::OP_REF) ? area_new : ref_area_q;
			dx_s1   <= dx;
			dy_s1   <= dy;
			sx_s1   <= sx;
			sy_s1   <= sy;
		end
	end

	// Deviation of each scaled displacement from the summed shift, squared.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			vx[i] = (VW'(dx_s1[i]) <<< 2) - VW'(sx_s1);
			vy[i] = (VW'(dy_s1[i]) <<< 2) - VW'(sy_s1);
			px[i] = vx[i] * vx[i];
			py[i] = vy[i] * vy[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready2) begin
			kind_s2 <= kind_s1;
			elig_s2 <= elig_s1;
			area_s2 <= area_s1;
			sx_s2   <= sx_s1;
			sy_s2   <= sy_s1;
			for (int i = 0; i < 4; i++) begin
				sqx_s2[i] <= $unsigned(px[i]);
				sqy_s2[i] <= $unsigned(py[i]);
			end
		end
	end

	// Spread sums and the match test against four times the area.
	always_comb begin
		spx = SPW'(sqx_s2[0]) + SPW'(sqx_s2[1]) + SPW'(sqx_s2[2]) + SPW'(sqx_s2[3]);
		spy = SPW'(sqy_s2[0]) + SPW'(sqy_s2[1]) + SPW'(sqy_s2[2]) + SPW'(sqy_s2[3]);
		lim = {area_s2, 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ready3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready3) begin
			kind_s3 <= kind_s2;
			area_s3 <= area_s2;
			if (kind_s2 == epmm_pkg::RES_TRACK) begin
				matched_s3 <= elig_s2 && ((CMPW'(spx) <= CMPW'(lim)) ||
				                          (CMPW'(spy) <= CMPW'(lim)));
				shx_s3     <= epmm_pkg::SHIFT_W'(sx_s2);
				shy_s3     <= epmm_pkg::SHIFT_W'(sy_s2);
				spx_s3     <= epmm_pkg::SPREAD_W'(spx);
				spy_s3     <= epmm_pkg::SPREAD_W'(spy);
			end else begin
				matched_s3 <= 1'b0;
				shx_s3     <= '0;
				shy_s3     <= '0;
				spx_s3     <= '0;
				spy_s3     <= '0;
			end
		end
	end

	assign out_valid        = v_s3;
	assign result_kind      = kind_s3;
	assign matched          = matched_s3;
	assign shift_x_quarters = shx_s3;
	assign shift_y_quarters = shy_s3;
	assign spread_x         = spx_s3;
	assign spread_y         = spy_s3;
	assign area             = area_s3;

endmodule
`default_nettype wire

FILE: sv/extreme_point_motion_matcher_unit.sv
// Extreme-point motion matcher. Takes one point item per clock while in_ready
// is high and tracks the left, top, right and bottom extremes of the frame in
// progress; the last point of a frame, or a clear request, is written into a
// QUEUE_DEPTH-entry queue. The back end takes one queue entry per clock while
// the queue is not empty and its stages do not stall: a clear request empties
// the reference, a reference frame is merged into the reference extremes and
// its area stored, a tracked frame is compared against the reference. Results
// pass three register stages (displacements, squares, sums and match test),
// which stall while out_ready is low. The sustained rate is one item per clock;
// in_ready falls only when the queue fills because results are not being taken.
`default_nettype none
module extreme_point_motion_matcher_unit #(
	parameter int COORD_BITS  = 10,
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        req_type,
	input  wire logic [COORD_BITS-1:0]             pos_x,
	input  wire logic [COORD_BITS-1:0]             pos_y,
	input  wire logic                              frame_end,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   result_kind,
	output logic                                   matched,
	output logic signed [epmm_pkg::SHIFT_W-1:0]    shift_x_quarters,
	output logic signed [epmm_pkg::SHIFT_W-1:0]    shift_y_quarters,
	output logic [epmm_pkg::SPREAD_W-1:0]          spread_x,
	output logic [epmm_pkg::SPREAD_W-1:0]          spread_y,
	output logic [epmm_pkg::AREA_W-1:0]            area
);

	localparam int EW = 2 + 8 * COORD_BITS;

	logic                       q_push;
	epmm_pkg::op_t              push_op;
	logic [7:0][COORD_BITS-1:0] push_ext;
	logic                       q_pop;
	logic [EW-1:0]              pop_data;
	epmm_pkg::q_status_t        q_status;
	epmm_pkg::op_t              head_op;
	logic [7:0][COORD_BITS-1:0] head_ext;

	epmm_front #(
		.CW(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.frame_end (frame_end),
		.q_status  (q_status),
		.push      (q_push),
		.push_op   (push_op),
		.push_ext  (push_ext)
	);

	epmm_queue #(
		.W     (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_op, push_ext}),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	assign head_op  = epmm_pkg::op_t'(pop_data[EW-1 -: 2]);
	assign head_ext = pop_data[8*COORD_BITS-1:0];

	epmm_back #(
		.CW(COORD_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_status         (q_status),
		.head_op          (head_op),
		.head_ext         (head_ext),
		.pop              (q_pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.result_kind      (result_kind),
		.matched          (matched),
		.shift_x_quarters (shift_x_quarters),
		.shift_y_quarters (shift_y_quarters),
		.spread_x         (spread_x),
		.spread_y         (spread_y),
		.area             (area)
	);

`ifndef SYNTHESIS
	// The front end never writes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("queue written while full");

	// The back end never takes an entry from an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("queue read while empty");

	// A reference result carries no match, shift or spread.
	a_ref_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == epmm_pkg::RES_REF) |->
		(!matched && shift_x_quarters == '0 && shift_y_quarters == '0 &&
		 spread_x == '0 && spread_y == '0))
		else $error("reference result with nonzero comparison fields");
`endif

endmodule
`default_nettype wire
